// ===== rtl/ikhm_pkg.sv =====
// ----------------------------------------------------------------------------
// ikhm_pkg
// Shared types, constants and the key mix for the integer-key hash map.
// ----------------------------------------------------------------------------
package ikhm_pkg;

	localparam int KEY_W  = 32;
	localparam int VAL_W  = 32;
	localparam int LEN_W  = 11;
	localparam int FUNC_W = 2;
	localparam int STAT_W = 2;

	localparam int CAPACITY_DEF    = 1024;
	localparam int PROBE_LIMIT_DEF = 8;

	localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(1024);
	localparam logic [KEY_W-1:0] GOLDEN    = 32'd2654435761;

	// mix is done as add-shift / xor-shift pairs, one pair a cycle
	localparam int MIX_ROUNDS = 4;
	// remainder bits retired per cycle
	localparam int MOD_BITS   = 4;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_PUT    = 2'd0,
		FUNC_GET    = 2'd1,
		FUNC_REMOVE = 2'd2
	} func_t;

	typedef enum logic [STAT_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_MISSING = 2'd1,
		STAT_FULL    = 2'd2
	} status_t;

	typedef struct packed {
		logic             valid;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] value;
	} entry_t;

	function automatic logic [KEY_W-1:0] mix_pair(input logic [KEY_W-1:0] k,
		input logic [1:0] round);
		logic [KEY_W-1:0] t;
		t = k;
		case (round)
			2'd0: begin
				t = t + (t << 12);
				t = t ^ (t >> 22);
			end
			2'd1: begin
				t = t + (t << 4);
				t = t ^ (t >> 9);
			end
			2'd2: begin
				t = t + (t << 10);
				t = t ^ (t >> 2);
			end
			default: begin
				t = t + (t << 7);
				t = t ^ (t >> 12);
			end
		endcase
		return t;
	endfunction

endpackage

// ===== rtl/int_key_linear_probe_hash_map.sv =====
// ----------------------------------------------------------------------------
// int_key_linear_probe_hash_map
// Open-addressing hash table with 32-bit keys and linear probing.
// ----------------------------------------------------------------------------
// Requests enter on s_axis (tuser = func, tdata = key, value); one response
// beat per request leaves on m_axis (tuser = status, tdata = found_value,
// entry_count). table_length must be written on the cfg channel only while
// idle; the block itself does not enforce this. A request passes through
// accept, hash (mix, multiply and hand-off), remainder, read issue, one
// evaluation per probed slot (1 to PROBE_LIMIT) and response. Func 3 and a
// put to a full table skip hashing and probing and go straight to the
// response. The probe walk is paced by the single read port of the slot
// memory, the home slot by the iterative remainder unit.
// After reset the block sweeps the slot memory once, one slot a cycle,
// clearing the valid bits, with s_axis_tready low until the sweep is done.
// cfg_ready is always high. A stalled m_axis keeps its beat; the next
// request is still accepted and runs until its own response must be loaded.
// ----------------------------------------------------------------------------
module int_key_linear_probe_hash_map #(
	parameter int CAPACITY    = ikhm_pkg::CAPACITY_DEF,
	parameter int PROBE_LIMIT = ikhm_pkg::PROBE_LIMIT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // key[31:0], value[63:32]
	input  logic [1:0]  s_axis_tuser,   // func[1:0]
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // found_value[31:0], entry_count[42:32], zero
	output logic [1:0]  m_axis_tuser,   // status[1:0]
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [10:0] cfg_data        // table_length
);

	localparam int AW     = $clog2(CAPACITY);
	localparam int LW     = ikhm_pkg::LEN_W;
	localparam int PW     = (PROBE_LIMIT > 1) ? $clog2(PROBE_LIMIT) : 1;
	localparam int SW     = (AW > LW) ? AW + 1 : LW + 1;
	localparam int CAP_CL = (CAPACITY > 2047) ? 2047 : CAPACITY;
	localparam int PAD_W  = 48 - ikhm_pkg::VAL_W - LW;

	localparam logic [LW-1:0] CAP_LEN = LW'(CAP_CL);

	typedef enum logic [6:0] {
		ST_CLEAR = 7'b0000001,
		ST_IDLE  = 7'b0000010,
		ST_HASH  = 7'b0000100,
		ST_MOD   = 7'b0001000,
		ST_ISSUE = 7'b0010000,
		ST_EVAL  = 7'b0100000,
		ST_RESP  = 7'b1000000
	} state_t;

	state_t                     state_q;
	logic [AW-1:0]              clr_q;
	logic [LW-1:0]              tlen_q;
	logic [LW-1:0]              count_q;
	logic [ikhm_pkg::FUNC_W-1:0] func_q;
	logic [ikhm_pkg::KEY_W-1:0] key_q;
	logic [ikhm_pkg::VAL_W-1:0] value_q;
	logic [AW-1:0]              slot_q;
	logic [PW-1:0]              probe_q;
	ikhm_pkg::status_t          res_status_q;
	logic [ikhm_pkg::VAL_W-1:0] res_found_q;

	logic                       out_valid_q;
	ikhm_pkg::status_t          out_status_q;
	logic [ikhm_pkg::VAL_W-1:0] out_found_q;
	logic [LW-1:0]              out_count_q;

	logic [LW-1:0]              len;
	logic                       accept;
	logic                       hash_start;
	logic                       hash_done;
	logic [ikhm_pkg::KEY_W-1:0] hash_val;
	logic                       mod_done;
	logic [LW-1:0]              mod_rem;

	logic                       wr_en;
	logic [AW-1:0]              wr_addr;
	ikhm_pkg::entry_t           wr_data;
	logic                       rd_en;
	logic [AW-1:0]              rd_addr;
	ikhm_pkg::entry_t           rd_data;

	logic [SW-1:0]              slot_inc;
	logic [AW-1:0]              slot_nxt;
	logic                       key_eq;
	logic                       hit;
	logic                       last_probe;
	logic                       out_free;

	always_comb begin
		if (tlen_q == '0)
			len = LW'(1);
		else if (tlen_q > CAP_LEN)
			len = CAP_LEN;
		else
			len = tlen_q;
	end

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign hash_start = accept &&
		(s_axis_tuser == ikhm_pkg::FUNC_GET || s_axis_tuser == ikhm_pkg::FUNC_REMOVE ||
		(s_axis_tuser == ikhm_pkg::FUNC_PUT && count_q < len));

	assign slot_inc   = SW'(slot_q) + SW'(1);
	assign slot_nxt   = (slot_inc == SW'(len)) ? '0 : AW'(slot_inc);
	assign key_eq     = rd_data.key == key_q;
	assign hit        = (func_q == ikhm_pkg::FUNC_PUT) ? (!rd_data.valid || key_eq)
	                                                   : (rd_data.valid && key_eq);
	assign last_probe = probe_q == PW'(PROBE_LIMIT - 1);
	assign out_free   = !out_valid_q || m_axis_tready;

	ikhm_hash u_hash (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (hash_start),
		.key    (s_axis_tdata[31:0]),
		.done   (hash_done),
		.hash   (hash_val)
	);

	ikhm_mod u_mod (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (hash_done),
		.dividend  (hash_val),
		.divisor   (len),
		.done      (mod_done),
		.remainder (mod_rem)
	);

	ikhm_store #(
		.DEPTH (CAPACITY),
		.AW    (AW)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = slot_q;
		wr_data = '{valid: 1'b1, key: key_q, value: value_q};
		rd_en   = 1'b0;
		rd_addr = slot_q;
		case (state_q)
			ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = clr_q;
				wr_data = '0;
			end
			ST_ISSUE: begin
				rd_en = 1'b1;
			end
			ST_EVAL: begin
				if (hit) begin
					wr_en = (func_q == ikhm_pkg::FUNC_PUT) ||
					        (func_q == ikhm_pkg::FUNC_REMOVE);
					if (func_q == ikhm_pkg::FUNC_REMOVE)
						wr_data = '0;
				end else if (!last_probe) begin
					rd_en   = 1'b1;
					rd_addr = slot_nxt;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			clr_q        <= '0;
			tlen_q       <= ikhm_pkg::LEN_RESET;
			count_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid)
				tlen_q <= cfg_data;
			if (out_valid_q && m_axis_tready && state_q != ST_RESP)
				out_valid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(CAPACITY - 1))
						state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (accept)
						state_q <= hash_start ? ST_HASH : ST_RESP;
				end
				ST_HASH: begin
					if (hash_done)
						state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (mod_done)
						state_q <= ST_ISSUE;
				end
				ST_ISSUE: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					if (hit) begin
						state_q <= ST_RESP;
						if (func_q == ikhm_pkg::FUNC_PUT && !rd_data.valid)
							count_q <= count_q + LW'(1);
						else if (func_q == ikhm_pkg::FUNC_REMOVE && count_q != '0)
							count_q <= count_q - LW'(1);
					end else if (last_probe) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					func_q      <= s_axis_tuser;
					key_q       <= s_axis_tdata[31:0];
					value_q     <= s_axis_tdata[63:32];
					res_found_q <= '0;
					res_status_q <= (s_axis_tuser == ikhm_pkg::FUNC_PUT) ?
						ikhm_pkg::STAT_FULL : ikhm_pkg::STAT_MISSING;
				end
			end
			ST_MOD: begin
				slot_q  <= AW'(mod_rem);
				probe_q <= '0;
			end
			ST_EVAL: begin
				if (hit) begin
					res_status_q <= ikhm_pkg::STAT_OK;
					if (func_q == ikhm_pkg::FUNC_GET)
						res_found_q <= rd_data.value;
				end else begin
					slot_q  <= slot_nxt;
					probe_q <= probe_q + PW'(1);
				end
			end
			ST_RESP: begin
				if (out_free) begin
					out_status_q <= res_status_q;
					out_found_q  <= res_found_q;
					out_count_q  <= count_q;
				end
			end
			default: begin
			end
		endcase
	end

	assign s_axis_tready = state_q == ST_IDLE;
	assign cfg_ready     = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_status_q;
	assign m_axis_tdata  = {{PAD_W{1'b0}}, out_count_q, out_found_q};

	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !wr_en)
		else $error("slot write while idle");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q != ST_IDLE)
		else $error("request accepted but no work started");

	a_count_only_eval: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_EVAL |=> $stable(count_q))
		else $error("entry count changed outside slot evaluation");

	a_no_rw_same_slot: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("read and write of the same slot in one cycle");

endmodule

// ===== rtl/ikhm_hash.sv =====
// ----------------------------------------------------------------------------
// ikhm_hash
// Multi-cycle key mix followed by the golden-ratio multiply (mod 2^32).
// ----------------------------------------------------------------------------
module ikhm_hash (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [ikhm_pkg::KEY_W-1:0] key,
	output logic                      done,
	output logic [ikhm_pkg::KEY_W-1:0] hash
);

	localparam int SW = $clog2(ikhm_pkg::MIX_ROUNDS + 1);

	logic                       busy_q;
	logic                       done_q;
	logic [SW-1:0]              step_q;
	logic [ikhm_pkg::KEY_W-1:0] h_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (step_q == SW'(ikhm_pkg::MIX_ROUNDS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					step_q <= step_q + SW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			h_q <= key;
		end else if (busy_q) begin
			if (step_q == SW'(ikhm_pkg::MIX_ROUNDS)) begin
				h_q <= ikhm_pkg::KEY_W'((h_q >> 3) * ikhm_pkg::GOLDEN);
			end else begin
				h_q <= ikhm_pkg::mix_pair(h_q, step_q[1:0]);
			end
		end
	end

	assign done = done_q;
	assign hash = h_q;

endmodule

// ===== rtl/ikhm_mod.sv =====
// ----------------------------------------------------------------------------
// ikhm_mod
// Iterative remainder of a 32-bit hash by the table length, MOD_BITS bits a cycle.
// ----------------------------------------------------------------------------
module ikhm_mod (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [ikhm_pkg::KEY_W-1:0] dividend,
	input  logic [ikhm_pkg::LEN_W-1:0] divisor,
	output logic                       done,
	output logic [ikhm_pkg::LEN_W-1:0] remainder
);

	localparam int ITERS = ikhm_pkg::KEY_W / ikhm_pkg::MOD_BITS;
	localparam int CW    = $clog2(ITERS);
	localparam int RW    = ikhm_pkg::LEN_W + 1;

	logic                       busy_q;
	logic                       done_q;
	logic [CW-1:0]              cnt_q;
	logic [ikhm_pkg::KEY_W-1:0] d_q;
	logic [RW-1:0]              r_q;
	logic [ikhm_pkg::LEN_W-1:0] div_q;
	logic [ikhm_pkg::KEY_W-1:0] d_nxt;
	logic [RW-1:0]              r_nxt;

	always_comb begin
		r_nxt = r_q;
		d_nxt = d_q;
		for (int i = 0; i < ikhm_pkg::MOD_BITS; i++) begin
			r_nxt = {r_nxt[RW-2:0], d_nxt[ikhm_pkg::KEY_W-1]};
			d_nxt = d_nxt << 1;
			if (r_nxt >= {1'b0, div_q})
				r_nxt = r_nxt - {1'b0, div_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == CW'(ITERS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			d_q   <= dividend;
			r_q   <= '0;
			div_q <= divisor;
		end else if (busy_q) begin
			d_q <= d_nxt;
			r_q <= r_nxt;
		end
	end

	assign done      = done_q;
	assign remainder = r_q[ikhm_pkg::LEN_W-1:0];

endmodule

// ===== rtl/ikhm_store.sv =====
// ----------------------------------------------------------------------------
// ikhm_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ikhm_store #(
	parameter int DEPTH = ikhm_pkg::CAPACITY_DEF,
	parameter int AW    = $clog2(ikhm_pkg::CAPACITY_DEF)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  ikhm_pkg::entry_t wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output ikhm_pkg::entry_t rd_data
);

	ikhm_pkg::entry_t mem [DEPTH];
	ikhm_pkg::entry_t rd_q;

	always_ff @(posedge clk) begin
		if (wr_en)
			mem[wr_addr] <= wr_data;
		if (rd_en)
			rd_q <= mem[rd_addr];
	end

	assign rd_data = rd_q;

endmodule
